// ===== rtl/core/tmcg_pkg.sv =====
package tmcg_pkg;

	// text cells per screen row
	localparam int TEXT_COLS = 32;

	localparam int CELL_W  = 9;
	localparam int WORD_W  = 16;
	localparam int TIDX_W  = 8;
	localparam int COORD_W = 7;
	localparam int COLOR_W = 12;

	localparam int FONT_DEPTH = 256;
	localparam int PAL_DEPTH  = 16;
	localparam int PAL_AW     = $clog2(PAL_DEPTH);

	localparam int QUEUE_DEPTH = 2;

	// cell / TEXT_COLS as multiply by reciprocal; exact for 9-bit cells
	localparam int RECIP_SHIFT = 18;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = CELL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RECIP_SHIFT) + TEXT_COLS - 1) / TEXT_COLS);

	typedef enum logic [1:0] {
		OP_RENDER  = 2'd0,
		OP_FONT    = 2'd1,
		OP_PALETTE = 2'd2
	} op_t;

	// one render job handed from front to back
	typedef struct packed {
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] base_y;
		logic [31:0]        cols;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
	} job_t;

endpackage

// ===== rtl/core/text_mode_character_generator_core.sv =====
// Text-mode character generator: op OP_FONT writes a 16-bit font word (two per glyph),
// op OP_PALETTE writes a 12-bit RGB palette entry, op OP_RENDER emits the 32 pixels of one
// 4x8 text cell, column by column and row by row within a column, with last on the 32nd.
// After reset both stores are cleared to zero, one word per cycle, and the input stalls
// until the clear is done. Write items produce nothing; a render item yields one pixel
// per clock from the output stage while out_stall is low, and that pixel counter sets
// the sustained rate. Font and palette are read when the render item is accepted, so
// writes that follow a render never affect it. A two-deep job queue sits between the
// front end and the pixel stage, so the next items are taken while a cell is still
// being drawn.
module text_mode_character_generator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [tmcg_pkg::CELL_W-1:0]   cell_index,
	input  logic [tmcg_pkg::WORD_W-1:0]   cell_word,
	input  logic [tmcg_pkg::TIDX_W-1:0]   table_index,
	input  logic [tmcg_pkg::WORD_W-1:0]   table_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmcg_pkg::COORD_W-1:0]  pixel_x,
	output logic [tmcg_pkg::COORD_W-1:0]  pixel_y,
	output logic [7:0]                    red,
	output logic [7:0]                    green,
	output logic [7:0]                    blue,
	output logic                          last
);
	import tmcg_pkg::*;

	job_t front_job, head_job;
	logic front_valid, queue_full, queue_avail, queue_pop;

	tmcg_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.cell_index  (cell_index),
		.cell_word   (cell_word),
		.table_index (table_index),
		.table_data  (table_data),
		.job         (front_job),
		.job_valid   (front_valid),
		.job_full    (queue_full)
	);

	tmcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_job  (front_job),
		.full      (queue_full),
		.pop       (queue_pop),
		.head      (head_job),
		.not_empty (queue_avail)
	);

	tmcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_avail (queue_avail),
		.job_pop   (queue_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.last      (last)
	);

endmodule

// ===== rtl/core/tmcg_ram.sv =====
module tmcg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/core/tmcg_front.sv =====
module tmcg_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [tmcg_pkg::CELL_W-1:0]   cell_index,
	input  logic [tmcg_pkg::WORD_W-1:0]   cell_word,
	input  logic [tmcg_pkg::TIDX_W-1:0]   table_index,
	input  logic [tmcg_pkg::WORD_W-1:0]   table_data,
	output tmcg_pkg::job_t                job,
	output logic                          job_valid,
	input  logic                          job_full
);
	import tmcg_pkg::*;

	logic in_acc, do_render, do_font, do_pal;
	logic [6:0]          glyph;
	logic [TIDX_W-1:0]   font_a, font_b;
	logic [PAL_AW-1:0]   pal_bg, pal_fg;
	logic [WORD_W-1:0]   font_rd_a, font_rd_b;
	logic [COLOR_W-1:0]  pal_rd_a, pal_rd_b;

	logic                clr_busy_q;
	logic [TIDX_W-1:0]   clr_ptr_q;
	logic                font_we, pal_we;
	logic [TIDX_W-1:0]   font_waddr;
	logic [WORD_W-1:0]   font_wdata;
	logic [PAL_AW-1:0]   pal_waddr;
	logic [COLOR_W-1:0]  pal_wdata;

	logic                s1_vld_q;
	logic [CELL_W-1:0]   cell_s1;
	logic [PROD_W-1:0]   prod_s1;

	logic [CELL_W-1:0]   q_est, q_fix;
	logic [15:0]         q_times;
	logic [9:0]          r_est, r_fix;

	assign in_acc    = in_valid && !in_stall;
	assign do_render = in_acc && (op == OP_RENDER);
	assign do_font   = in_acc && (op == OP_FONT);
	assign do_pal    = in_acc && (op == OP_PALETTE);
	assign in_stall  = clr_busy_q || (s1_vld_q && job_full);

	assign glyph  = cell_word[6:0];
	assign font_a = {glyph, 1'b0};
	assign font_b = {glyph, 1'b1};
	assign pal_bg = cell_word[11:8];
	assign pal_fg = cell_word[15:12];

	// after reset both stores are zeroed, one font word per cycle
	assign font_we    = do_font || clr_busy_q;
	assign font_waddr = clr_busy_q ? clr_ptr_q : table_index;
	assign font_wdata = clr_busy_q ? '0 : table_data;
	assign pal_we     = do_pal || clr_busy_q;
	assign pal_waddr  = clr_busy_q ? clr_ptr_q[PAL_AW-1:0] : table_index[PAL_AW-1:0];
	assign pal_wdata  = clr_busy_q ? '0 : table_data[COLOR_W-1:0];

	tmcg_ram #(.WIDTH(WORD_W), .DEPTH(FONT_DEPTH)) u_font (
		.clk     (clk),
		.we      (font_we),
		.waddr   (font_waddr),
		.wdata   (font_wdata),
		.re      (do_render),
		.raddr_a (font_a),
		.raddr_b (font_b),
		.rdata_a (font_rd_a),
		.rdata_b (font_rd_b)
	);

	tmcg_ram #(.WIDTH(COLOR_W), .DEPTH(PAL_DEPTH)) u_pal (
		.clk     (clk),
		.we      (pal_we),
		.waddr   (pal_waddr),
		.wdata   (pal_wdata),
		.re      (do_render),
		.raddr_a (pal_bg),
		.raddr_b (pal_fg),
		.rdata_a (pal_rd_a),
		.rdata_b (pal_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_ptr_q  <= '0;
			s1_vld_q   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
				if (clr_ptr_q == TIDX_W'(FONT_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (do_render) begin
				s1_vld_q <= 1'b1;
			end else if (!job_full) begin
				s1_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_render) begin
			cell_s1 <= cell_index;
			prod_s1 <= PROD_W'(cell_index) * PROD_W'(RECIP);
		end
	end

	// quotient estimate, then one correction step
	always_comb begin
		q_est   = prod_s1[RECIP_SHIFT +: CELL_W];
		q_times = 16'(q_est) * 16'(TEXT_COLS);
		r_est   = 10'(16'(cell_s1) - q_times);
		if (r_est >= 10'(TEXT_COLS)) begin
			r_fix = r_est - 10'(TEXT_COLS);
			q_fix = q_est + 1'b1;
		end else begin
			r_fix = r_est;
			q_fix = q_est;
		end
	end

	always_comb begin
		job.base_x = {r_fix[4:0], 2'b00};
		job.base_y = {q_fix[3:0], 3'b000};
		job.cols   = {font_rd_a, font_rd_b};
		job.back   = pal_rd_a;
		job.fore   = pal_rd_b;
	end

	assign job_valid = s1_vld_q;

endmodule

// ===== rtl/core/tmcg_queue.sv =====
module tmcg_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmcg_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output tmcg_pkg::job_t head,
	output logic           not_empty
);
	import tmcg_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/core/tmcg_back.sv =====
module tmcg_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tmcg_pkg::job_t               job,
	input  logic                         job_avail,
	output logic                         job_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tmcg_pkg::COORD_W-1:0] pixel_x,
	output logic [tmcg_pkg::COORD_W-1:0] pixel_y,
	output logic [7:0]                   red,
	output logic [7:0]                   green,
	output logic [7:0]                   blue,
	output logic                         last
);
	import tmcg_pkg::*;

	logic [4:0]         k_q;
	logic [1:0]         col;
	logic [2:0]         row;
	logic               lit, load, k_end;
	logic [COLOR_W-1:0] color;

	assign col   = k_q[4:3];
	assign row   = k_q[2:0];
	// column byte order: word 0 high, word 0 low, word 1 high, word 1 low
	assign lit   = job.cols[{~col, row}];
	assign color = lit ? job.fore : job.back;
	assign k_end = (k_q == 5'd31);

	assign load    = job_avail && (!out_valid || !out_stall);
	assign job_pop = load && k_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			k_q       <= '0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				k_q       <= k_q + 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_x <= job.base_x + COORD_W'(col);
			pixel_y <= job.base_y + COORD_W'(row);
			red     <= {color[11:8], color[11:8]};
			green   <= {color[7:4], color[7:4]};
			blue    <= {color[3:0], color[3:0]};
			last    <= k_end;
		end
	end

endmodule

// ===== tb/sv/tmcg_checker.sv =====
module tmcg_checker
	import tmcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         op,
	input  logic [CELL_W-1:0]  cell_index,
	input  logic [WORD_W-1:0]  cell_word,
	input  logic [TIDX_W-1:0]  table_index,
	input  logic [WORD_W-1:0]  table_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [COORD_W-1:0] pixel_x,
	input  logic [COORD_W-1:0] pixel_y,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue,
	input  logic               last,
	output int                 errors,
	output int                 pending,
	output int                 cells_drawn,
	output int                 table_writes,
	output int                 pixels_checked
);

	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [7:0]         r;
		logic [7:0]         g;
		logic [7:0]         b;
		logic               last;
	} pixel_t;

	logic [WORD_W-1:0]  font_shadow [FONT_DEPTH];
	logic [COLOR_W-1:0] palette_shadow [PAL_DEPTH];
	pixel_t             pixel_fifo [$];

	// nibble times 17 is the nibble repeated
	function automatic logic [7:0] widen4(input logic [3:0] n);
		return {n, n};
	endfunction

	task automatic predict_cell(input logic [CELL_W-1:0] cidx, input logic [WORD_W-1:0] word);
		logic [6:0]         glyph;
		logic [COLOR_W-1:0] fore;
		logic [COLOR_W-1:0] back;
		logic [COLOR_W-1:0] color;
		logic [31:0]        glyph_bits;
		logic [COORD_W-1:0] base_x;
		logic [COORD_W-1:0] base_y;
		pixel_t             p;
		glyph = word[6:0];
		back = palette_shadow[word[11:8]];
		fore = palette_shadow[word[15:12]];
		glyph_bits = {font_shadow[{glyph, 1'b0}], font_shadow[{glyph, 1'b1}]};
		base_x = COORD_W'((int'(cidx) % TEXT_COLS) * 4);
		base_y = COORD_W'((int'(cidx) / TEXT_COLS) * 8);
		for (int cx = 0; cx < 4; cx++) begin
			for (int ry = 0; ry < 8; ry++) begin
				// column cx is byte 3-cx of the glyph pair, row ry its bit ry
				color = glyph_bits[24 - 8 * cx + ry] ? fore : back;
				p.x = base_x + COORD_W'(cx);
				p.y = base_y + COORD_W'(ry);
				p.r = widen4(color[11:8]);
				p.g = widen4(color[7:4]);
				p.b = widen4(color[3:0]);
				p.last = (cx == 3) && (ry == 7);
				pixel_fifo.push_back(p);
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: pixel %0d %s expected %0d actual %0d",
					$time, pixels_checked, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		if (!arst_n) begin
			for (int i = 0; i < FONT_DEPTH; i++)
				font_shadow[i] = '0;
			for (int i = 0; i < PAL_DEPTH; i++)
				palette_shadow[i] = '0;
			pixel_fifo.delete();
			errors = 0;
			pending = 0;
			cells_drawn = 0;
			table_writes = 0;
			pixels_checked = 0;
		end else begin
			if (in_valid && !in_stall) begin
				case (op)
					OP_FONT: begin
						font_shadow[table_index] = table_data;
						table_writes++;
					end
					OP_PALETTE: begin
						palette_shadow[table_index[PAL_AW-1:0]] = table_data[COLOR_W-1:0];
						table_writes++;
					end
					OP_RENDER: begin
						predict_cell(cell_index, cell_word);
						cells_drawn++;
					end
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (pixel_fifo.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected pixel, expected none, actual x %0d y %0d",
							$time, pixel_x, pixel_y);
				end else begin
					want = pixel_fifo.pop_front();
					check_field("pixel_x", want.x, pixel_x);
					check_field("pixel_y", want.y, pixel_y);
					check_field("red", want.r, red);
					check_field("green", want.g, green);
					check_field("blue", want.b, blue);
					check_field("last", want.last, last);
					pixels_checked++;
				end
			end
			pending = pixel_fifo.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import tmcg_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 450;
	localparam int         LONG_HOLD = 400;
	localparam int         IDLE_PCT = 11;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = OP_RENDER;
	logic [CELL_W-1:0]  cell_index = '0;
	logic [WORD_W-1:0]  cell_word = '0;
	logic [TIDX_W-1:0]  table_index = '0;
	logic [WORD_W-1:0]  table_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;
	logic               last;

	int errors;
	int pending;
	int cells_drawn;
	int table_writes;
	int pixels_checked;

	bit in_calm = 1'b0;
	bit out_calm = 1'b0;
	int hold_req = 0;
	int hold_done = 0;

	text_mode_character_generator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.cell_index  (cell_index),
		.cell_word   (cell_word),
		.table_index (table_index),
		.table_data  (table_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last        (last)
	);

	tmcg_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.op             (op),
		.cell_index     (cell_index),
		.cell_word      (cell_word),
		.table_index    (table_index),
		.table_data     (table_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.red            (red),
		.green          (green),
		.blue           (blue),
		.last           (last),
		.errors         (errors),
		.pending        (pending),
		.cells_drawn    (cells_drawn),
		.table_writes   (table_writes),
		.pixels_checked (pixels_checked)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	// pixel sink: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req != hold_done) begin
				hold_done = hold_req;
				out_stall = 1'b1;
				repeat (LONG_HOLD - 1) @(negedge clk);
			end else begin
				out_stall = !out_calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [1:0] o, input logic [CELL_W-1:0] cidx,
		input logic [WORD_W-1:0] word, input logic [TIDX_W-1:0] tidx,
		input logic [WORD_W-1:0] tdata);
		while (!in_calm && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid = 1'b0;
			op = 2'($urandom);
			cell_word = 16'($urandom);
			@(negedge clk);
		end
		op = o;
		cell_index = cidx;
		cell_word = word;
		table_index = tidx;
		table_data = tdata;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic random_item();
		int         pick;
		logic [1:0] o;
		logic [8:0] cidx;
		pick = $urandom_range(99);
		if (pick < 55)
			o = OP_RENDER;
		else if (pick < 80)
			o = OP_FONT;
		else if (pick < 95)
			o = OP_PALETTE;
		else
			o = OP_UNUSED;
		// mostly on-screen cells, now and then beyond the last row
		cidx = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(383));
		send_item(o, cidx, 16'($urandom), 8'($urandom), 16'($urandom));
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// stores still clear: all black
		send_item(OP_RENDER, 9'd0, 16'h0000, 8'h00, 16'h0000);
		send_item(OP_PALETTE, 9'd0, 16'h0000, 8'h00, 16'hF000);
		send_item(OP_PALETTE, 9'd0, 16'h0000, 8'h0F, 16'hFFFF);
		send_item(OP_PALETTE, 9'd0, 16'h0000, 8'hF5, 16'h0A5C);
		send_item(OP_PALETTE, 9'd0, 16'h0000, 8'h01, 16'h7123);
		send_item(OP_PALETTE, 9'd0, 16'h0000, 8'h0A, 16'h0F00);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd2, 16'h8001);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd3, 16'h55AA);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd254, 16'hFFFF);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd255, 16'h0F0F);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd0, 16'hFFFF);
		send_item(OP_FONT, 9'd0, 16'h0000, 8'd1, 16'h0000);
		send_item(OP_RENDER, 9'd0, 16'hF001, 8'h00, 16'h0000);
		send_item(OP_RENDER, 9'd383, 16'h15FF, 8'h00, 16'h0000);
		send_item(OP_RENDER, 9'd511, 16'hFFFF, 8'hFF, 16'hFFFF);
		// blink set, must not matter
		send_item(OP_RENDER, 9'd31, 16'hA080, 8'h00, 16'h0000);
		send_item(OP_RENDER, 9'd31, 16'hA000, 8'h00, 16'h0000);
		send_item(OP_UNUSED, 9'h1FF, 16'hFFFF, 8'hFF, 16'hFFFF);
		send_item(OP_RENDER, 9'd32, 16'h0F7F, 8'h00, 16'h0000);
		send_item(OP_UNUSED, 9'd0, 16'h0000, 8'h00, 16'h0000);
		send_item(OP_RENDER, 9'd352, 16'h5A01, 8'h00, 16'h0000);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				hold_req++;
			if (i == 250) begin
				in_valid = 1'b0;
				do @(negedge clk); while (pending != 0);
			end
			if (i == 300) begin
				in_calm = 1'b1;
				out_calm = 1'b1;
			end
			if (i == 380) begin
				in_calm = 1'b0;
				out_calm = 1'b0;
			end
			random_item();
		end
		in_valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);

		$display("tb: %0d cells drawn, %0d font/palette writes, %0d pixels compared",
			cells_drawn, table_writes, pixels_checked);
		$display("tb: included off-screen cells, ignored op code, long sink hold and drain pause");
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
